>>> design/sdfr_pkg.sv
`default_nettype none

package sdfr_pkg;

  localparam int DataDepth = 256;
  localparam int CountW    = $clog2(DataDepth + 1);

  localparam int ByteW   = 8;
  localparam int KindW   = 3;
  localparam int PCountW = 9;
  localparam int WaitW   = 16;
  localparam int EventW  = 3;

  localparam logic [ByteW-1:0] ByteSot     = 8'h01;
  localparam logic [ByteW-1:0] ByteEot     = 8'h04;
  localparam logic [ByteW-1:0] ByteDataSot = 8'h02;
  localparam logic [ByteW-1:0] ByteDataEot = 8'h03;

  localparam logic [ByteW-1:0] ExpectedVersionRst = 8'd4;

endpackage

`default_nettype wire

>>> design/sdfr_if.sv
`default_nettype none

interface sdfr_rx_if
  import sdfr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sdfr_res_if
  import sdfr_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [KindW-1:0]         out_kind;
  logic [ByteW-1:0]         payload_byte;
  logic [PCountW-1:0]       payload_count;
  logic [ByteW-1:0]         peer_version;
  logic [WaitW-1:0]         peer_wait;
  logic [ByteW-1:0]         peer_repeat;
  logic [ByteW-1:0]         card_state;
  logic signed [ByteW-1:0]  loop_count;
  logic [EventW-1:0]        status_event;

  modport source (
    output valid, output out_kind, output payload_byte, output payload_count,
    output peer_version, output peer_wait, output peer_repeat, output card_state,
    output loop_count, output status_event, input ready
  );
  modport sink (
    input valid, input out_kind, input payload_byte, input payload_count,
    input peer_version, input peer_wait, input peer_repeat, input card_state,
    input loop_count, input status_event, output ready
  );
endinterface

`default_nettype wire

>>> design/status_and_data_frame_receiver.sv
// channel   | dir | word                                  | handshake
// ----------+-----+---------------------------------------+------------
// rx        | in  | rx_byte                               | valid/ready
// res       | out | kind, payload byte/count, peer status | valid/ready
// cfg       | in  | expected_version                      | cfg_wr_en
//
// one word in, one word out; a byte is taken every cycle while the output
// register is empty or being drained, and its result is valid in the next cycle
// the parse state and the output register sit back to back, so a stall on
// res holds rx only once the output register is full
// rst is synchronous and returns the parser to idle outside any frame
`default_nettype none

module status_and_data_frame_receiver
  import sdfr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [ByteW-1:0] cfg_wr_data,
  sdfr_rx_if.sink               rx,
  sdfr_res_if.source            res
);

  localparam logic [1:0] ModeIdle   = 2'd0;
  localparam logic [1:0] ModeData   = 2'd1;
  localparam logic [1:0] ModeStatus = 2'd2;
  localparam logic [1:0] ModeSkip   = 2'd3;

  localparam logic [2:0] FieldVersion = 3'd0;
  localparam logic [2:0] FieldWaitLo  = 3'd1;
  localparam logic [2:0] FieldWaitHi  = 3'd2;
  localparam logic [2:0] FieldRepeat  = 3'd3;
  localparam logic [2:0] FieldCard    = 3'd4;
  localparam logic [2:0] FieldLoop    = 3'd5;

  localparam logic [KindW-1:0] KindNone     = 3'd0;
  localparam logic [KindW-1:0] KindByte     = 3'd1;
  localparam logic [KindW-1:0] KindEnd      = 3'd2;
  localparam logic [KindW-1:0] KindOverflow = 3'd3;
  localparam logic [KindW-1:0] KindStatus   = 3'd4;

  localparam logic [EventW-1:0] EvNone       = 3'd0;
  localparam logic [EventW-1:0] EvVersionErr = 3'd1;
  localparam logic [EventW-1:0] EvProcessing = 3'd2;
  localparam logic [EventW-1:0] EvRepeat     = 3'd3;
  localparam logic [EventW-1:0] EvDone       = 3'd4;

  localparam logic [CountW-1:0] DepthCount = CountW'(DataDepth);

  logic [ByteW-1:0]  expected_version;
  logic [1:0]        rx_mode, rx_mode_next;
  logic [CountW-1:0] data_count, data_count_next;
  logic [2:0]        field_index, field_index_next;
  logic [ByteW-1:0]  version_reg, version_reg_next;
  logic [WaitW-1:0]  wait_reg, wait_reg_next;
  logic [ByteW-1:0]  repeat_reg, repeat_reg_next;
  logic [ByteW-1:0]  card_reg, card_reg_next;
  logic [ByteW-1:0]  loop_reg, loop_reg_next;
  logic              wait_toggle, wait_toggle_next;

  logic [KindW-1:0]  kind;
  logic [ByteW-1:0]  pbyte;
  logic [EventW-1:0] status_ev;
  logic              react;
  logic [31:0]       count_ext;
  logic              accept;
  logic              out_valid;

  assign rx.ready = !out_valid || res.ready;
  assign accept   = rx.valid && rx.ready;

  assign react = (wait_reg == '0) || (repeat_reg != '0) || wait_toggle;

  always_comb begin
    rx_mode_next     = rx_mode;
    data_count_next  = data_count;
    field_index_next = field_index;
    version_reg_next = version_reg;
    wait_reg_next    = wait_reg;
    repeat_reg_next  = repeat_reg;
    card_reg_next    = card_reg;
    loop_reg_next    = loop_reg;
    wait_toggle_next = wait_toggle;
    kind             = KindNone;
    pbyte            = '0;
    status_ev        = EvNone;
    unique case (rx_mode)
      ModeData: begin
        if (rx.rx_byte == ByteDataEot) begin
          kind         = KindEnd;
          rx_mode_next = ModeIdle;
        end else if (data_count < DepthCount) begin
          data_count_next = data_count + 1'b1;
          kind            = KindByte;
          pbyte           = rx.rx_byte;
        end else begin
          kind            = KindOverflow;
          data_count_next = '0;
          rx_mode_next    = ModeIdle;
        end
      end
      ModeStatus: begin
        unique case (field_index)
          FieldVersion: begin
            version_reg_next = rx.rx_byte;
            field_index_next = FieldWaitLo;
          end
          FieldWaitLo: begin
            wait_toggle_next = wait_reg[0] ^ rx.rx_byte[0];
            wait_reg_next    = {{(WaitW-ByteW){1'b0}}, rx.rx_byte};
            field_index_next = FieldWaitHi;
          end
          FieldWaitHi: begin
            wait_reg_next    = {rx.rx_byte, wait_reg[ByteW-1:0]};
            field_index_next = FieldRepeat;
          end
          FieldRepeat: begin
            repeat_reg_next  = rx.rx_byte;
            field_index_next = FieldCard;
          end
          FieldCard: begin
            card_reg_next    = rx.rx_byte;
            field_index_next = FieldLoop;
          end
          default: begin
            loop_reg_next    = rx.rx_byte;
            field_index_next = FieldVersion;
            kind             = KindStatus;
            rx_mode_next     = ModeSkip;
            if (!react) begin
              status_ev = EvNone;
            end else if (version_reg != expected_version) begin
              status_ev = EvVersionErr;
            end else if (wait_reg != '0) begin
              status_ev = EvProcessing;
            end else if (repeat_reg != '0) begin
              status_ev = EvRepeat;
            end else begin
              status_ev = EvDone;
            end
          end
        endcase
      end
      ModeSkip: begin
        if (rx.rx_byte == ByteEot) begin
          rx_mode_next = ModeIdle;
        end
      end
      default: begin
        if (rx.rx_byte == ByteDataSot) begin
          data_count_next = '0;
          rx_mode_next    = ModeData;
        end else if (rx.rx_byte == ByteSot) begin
          field_index_next = FieldVersion;
          rx_mode_next     = ModeStatus;
        end
      end
    endcase
  end

  assign count_ext = 32'(data_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= ExpectedVersionRst;
    end else if (cfg_wr_en) begin
      expected_version <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_mode     <= ModeIdle;
      data_count  <= '0;
      field_index <= FieldVersion;
      version_reg <= '0;
      wait_reg    <= '0;
      repeat_reg  <= '0;
      card_reg    <= '0;
      loop_reg    <= '0;
      wait_toggle <= 1'b0;
    end else if (accept) begin
      rx_mode     <= rx_mode_next;
      data_count  <= data_count_next;
      field_index <= field_index_next;
      version_reg <= version_reg_next;
      wait_reg    <= wait_reg_next;
      repeat_reg  <= repeat_reg_next;
      card_reg    <= card_reg_next;
      loop_reg    <= loop_reg_next;
      wait_toggle <= wait_toggle_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.out_kind      <= kind;
      res.payload_byte  <= pbyte;
      res.payload_count <= count_ext[PCountW-1:0];
      res.peer_version  <= version_reg_next;
      res.peer_wait     <= wait_reg_next;
      res.peer_repeat   <= repeat_reg_next;
      res.card_state    <= card_reg_next;
      res.loop_count    <= $signed(loop_reg_next);
      res.status_event  <= status_ev;
    end
  end

  assign res.valid = out_valid;

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench
  import sdfr_pkg::*;
();

  localparam int HoldCycles  = 80;
  localparam int CycleLimit  = 500000;
  localparam int RandomItems = 760;
  localparam int Phases      = 6;

  typedef enum logic [1:0] {MODE_IDLE, MODE_DATA, MODE_STATUS, MODE_SKIP} parse_mode_t;

  typedef enum logic [2:0] {
    FLD_VERSION, FLD_WAIT_LO, FLD_WAIT_HI, FLD_REPEAT, FLD_CARD, FLD_LOOP
  } status_field_t;

  typedef enum logic [KindW-1:0] {
    KIND_NONE, KIND_DATA, KIND_END, KIND_OVERFLOW, KIND_STATUS
  } word_kind_t;

  typedef enum logic [EventW-1:0] {
    EV_NONE, EV_VERSION_ERR, EV_PROCESSING, EV_REPEAT, EV_DONE
  } status_event_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_RARE} stall_style_t;

  typedef struct {
    word_kind_t         kind;
    logic [ByteW-1:0]   data_byte;
    logic [PCountW-1:0] data_count;
    logic [ByteW-1:0]   version;
    logic [WaitW-1:0]   wait_word;
    logic [ByteW-1:0]   repeat_cnt;
    logic [ByteW-1:0]   card;
    logic [ByteW-1:0]   loop_cnt;
    status_event_t      ev;
  } frame_word_t;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [ByteW-1:0] cfg_wr_data;

  sdfr_rx_if  rx_if ();
  sdfr_res_if res_if ();

  status_and_data_frame_receiver u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rx          (rx_if),
    .res         (res_if)
  );

  // parser copy
  parse_mode_t        parse_mode    = MODE_IDLE;
  status_field_t      status_field  = FLD_VERSION;
  logic [PCountW-1:0] frame_len     = '0;
  logic [ByteW-1:0]   peer_version  = '0;
  logic [WaitW-1:0]   peer_wait     = '0;
  logic [ByteW-1:0]   peer_repeat   = '0;
  logic [ByteW-1:0]   peer_card     = '0;
  logic [ByteW-1:0]   peer_loop     = '0;
  logic               wait_lsb_flip = 1'b0;
  logic [ByteW-1:0]   want_version  = ExpectedVersionRst;

  frame_word_t awaited_words[$];
  frame_word_t want;
  int          errors     = 0;
  int          sent_items = 0;
  int          burst_left = 0;
  bit          gaps_on    = 1'b1;
  bit          hold_req   = 1'b0;

  stall_style_t stall_style = STALL_NONE;
  int           stall_left  = 0;
  int           hold_left   = 0;
  int           stall_phase = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic frame_word_t parse_byte(input logic [ByteW-1:0] b);
    frame_word_t w;
    logic        react;
    w.kind      = KIND_NONE;
    w.data_byte = '0;
    w.ev        = EV_NONE;
    case (parse_mode)
      MODE_DATA: begin
        if (b == ByteDataEot) begin
          w.kind     = KIND_END;
          parse_mode = MODE_IDLE;
        end else if (frame_len < DataDepth) begin
          frame_len   = frame_len + 1'b1;
          w.kind      = KIND_DATA;
          w.data_byte = b;
        end else begin
          w.kind     = KIND_OVERFLOW;
          frame_len  = '0;
          parse_mode = MODE_IDLE;
        end
      end
      MODE_STATUS: begin
        case (status_field)
          FLD_VERSION: begin
            peer_version = b;
            status_field = FLD_WAIT_LO;
          end
          FLD_WAIT_LO: begin
            wait_lsb_flip = peer_wait[0] ^ b[0];
            peer_wait     = {8'h00, b};
            status_field  = FLD_WAIT_HI;
          end
          FLD_WAIT_HI: begin
            peer_wait[15:8] = b;
            status_field    = FLD_REPEAT;
          end
          FLD_REPEAT: begin
            peer_repeat  = b;
            status_field = FLD_CARD;
          end
          FLD_CARD: begin
            peer_card    = b;
            status_field = FLD_LOOP;
          end
          default: begin
            peer_loop    = b;
            status_field = FLD_VERSION;
            parse_mode   = MODE_SKIP;
            w.kind       = KIND_STATUS;
            react = (peer_wait == 0) || (peer_repeat != 0) || wait_lsb_flip;
            if (!react) w.ev = EV_NONE;
            else if (peer_version != want_version) w.ev = EV_VERSION_ERR;
            else if (peer_wait != 0) w.ev = EV_PROCESSING;
            else if (peer_repeat != 0) w.ev = EV_REPEAT;
            else w.ev = EV_DONE;
          end
        endcase
      end
      MODE_SKIP: begin
        if (b == ByteEot) parse_mode = MODE_IDLE;
      end
      default: begin
        if (b == ByteDataSot) begin
          frame_len  = '0;
          parse_mode = MODE_DATA;
        end else if (b == ByteSot) begin
          status_field = FLD_VERSION;
          parse_mode   = MODE_STATUS;
        end
      end
    endcase
    w.data_count = frame_len;
    w.version    = peer_version;
    w.wait_word  = peer_wait;
    w.repeat_cnt = peer_repeat;
    w.card       = peer_card;
    w.loop_cnt   = peer_loop;
    return w;
  endfunction

  function automatic logic [ByteW-1:0] byte_other_than(input logic [ByteW-1:0] x);
    logic [ByteW-1:0] b;
    do b = ByteW'($urandom); while (b == x);
    return b;
  endfunction

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    if (gaps_on && burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
      if (gap > 0) begin
        rx_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (rx_if.ready !== 1'b1);
    awaited_words.push_back(parse_byte(b));
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send_data_frame(input int len, input bit close);
    send_byte(ByteDataSot);
    repeat (len) send_byte(byte_other_than(ByteDataEot));
    if (close) send_byte(ByteDataEot);
  endtask

  task automatic send_status_frame(input logic [ByteW-1:0] v, input logic [WaitW-1:0] w,
                                   input logic [ByteW-1:0] r, input logic [ByteW-1:0] c,
                                   input logic [ByteW-1:0] l, input int skip,
                                   input bit close);
    send_byte(ByteSot);
    send_byte(v);
    send_byte(w[7:0]);
    send_byte(w[15:8]);
    send_byte(r);
    send_byte(c);
    send_byte(l);
    repeat (skip) send_byte(byte_other_than(ByteEot));
    if (close) send_byte(ByteEot);
  endtask

  task automatic wait_for_drain();
    rx_if.valid <= 1'b0;
    do @(negedge clk); while (awaited_words.size() != 0);
  endtask

  task automatic write_expected_version(input logic [ByteW-1:0] v);
    wait_for_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en    <= 1'b0;
    want_version = v;
  endtask

  task automatic send_random_sequence();
    int               pick;
    int               len;
    logic [WaitW-1:0] w;
    logic [ByteW-1:0] v;
    logic [ByteW-1:0] r;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if ($urandom_range(0, 39) == 0) len = $urandom_range(DataDepth - 2, DataDepth + 2);
      else len = $urandom_range(0, 12);
      send_data_frame(len, $urandom_range(0, 9) != 0);
    end else if (pick < 88) begin
      case ($urandom_range(0, 2))
        0: w = '0;
        1: w = WaitW'($urandom_range(0, 3));
        default: w = WaitW'($urandom);
      endcase
      v = $urandom_range(0, 1) ? want_version : ByteW'($urandom);
      r = $urandom_range(0, 1) ? 8'h00 : ByteW'($urandom);
      send_status_frame(v, w, r, ByteW'($urandom), ByteW'($urandom), $urandom_range(0, 3),
                        $urandom_range(0, 9) != 0);
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(ByteW'($urandom));
    end
  endtask

  // noise outside frames, empty frame, markers inside a payload
  task automatic test_data_frames();
    send_byte(8'hFF);
    send_byte(ByteEot);
    send_byte(ByteDataEot);
    send_byte(8'h00);
    send_byte(ByteDataSot);
    send_byte(ByteDataEot);
    send_byte(ByteDataSot);
    send_byte(ByteSot);
    send_byte(ByteDataSot);
    send_byte(ByteEot);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(ByteDataEot);
  endtask

  // wait zero with matching version, then a lsb toggle with a wrong version
  task automatic test_status_frames();
    send_status_frame(ExpectedVersionRst, 16'h0000, 8'h00, 8'hFF, 8'h80, 0, 1'b1);
    send_status_frame(8'h03, 16'hFF01, ByteEot, 8'h00, 8'h7F, 2, 1'b1);
  endtask

  // full-depth frame, then one payload word too many
  task automatic test_data_overflow();
    send_data_frame(DataDepth, 1'b1);
    send_data_frame(DataDepth + 1, 1'b0);
    send_byte(ByteDataEot);
  endtask

  // long output stall while words keep coming
  task automatic test_output_stall();
    wait_for_drain();
    hold_req = 1'b1;
    gaps_on  = 1'b0;
    send_data_frame(40, 1'b1);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [ByteW-1:0] v;
    int               phase_end;
    for (int p = 0; p < Phases; p++) begin
      case (p)
        0: v = 8'h00;
        1: v = 8'hFF;
        2: v = ExpectedVersionRst;
        default: v = ByteW'($urandom);
      endcase
      write_expected_version(v);
      phase_end = sent_items + RandomItems / Phases;
      while (sent_items < phase_end) send_random_sequence();
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_data_frames();
    test_status_frames();
    test_data_overflow();
    test_output_stall();
    test_random_traffic();
    wait_for_drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // result side stall pattern
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (stall_left <= 0) begin
        stall_style = stall_style_t'($urandom_range(0, 3));
        stall_left  = $urandom_range(10, 150);
      end
      stall_left--;
      stall_phase++;
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        case (stall_style)
          STALL_NONE: res_if.ready <= 1'b1;
          STALL_RANDOM: res_if.ready <= 1'($urandom_range(0, 1));
          STALL_PERIODIC: res_if.ready <= (stall_phase % 4 == 0);
          default: res_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic void compare_field(input string name, input logic [WaitW-1:0] exp_v,
                                        input logic [WaitW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (awaited_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual kind %0d", $time,
                 res_if.out_kind);
        errors++;
      end else begin
        want = awaited_words.pop_front();
        compare_field("out_kind", want.kind, res_if.out_kind);
        compare_field("payload_byte", want.data_byte, res_if.payload_byte);
        compare_field("payload_count", want.data_count, res_if.payload_count);
        compare_field("peer_version", want.version, res_if.peer_version);
        compare_field("peer_wait", want.wait_word, res_if.peer_wait);
        compare_field("peer_repeat", want.repeat_cnt, res_if.peer_repeat);
        compare_field("card_state", want.card, res_if.card_state);
        compare_field("loop_count", want.loop_cnt, $unsigned(res_if.loop_count));
        compare_field("status_event", want.ev, res_if.status_event);
      end
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
